/* design/assert_macros.svh */
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, empty in synthesis.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CAI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("checked_int64_alu assertion failed");
`define CAI_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("checked_int64_alu implication failed");
`else
`define CAI_ASSERT(lbl, prop)
`define CAI_ASSERT_IMP(lbl, pre, post)
`endif
`endif

/* design/cai_pkg.sv */
// ------------------------------------------------------------------------
// cai_pkg
// Types, codes and constants of the checked 64-bit integer ALU.
// ------------------------------------------------------------------------
package cai_pkg;

  localparam int unsigned NumCells = 64;
  localparam logic [63:0] SignBit  = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_MOD = 4'd4, OP_EQ = 4'd5, OP_NE = 4'd6, OP_LT = 4'd7,
    OP_GT = 4'd8, OP_LE = 4'd9, OP_GE = 4'd10, OP_AND = 4'd11,
    OP_OR = 4'd12, OP_NEG = 4'd13, OP_NOT = 4'd14, OP_UNSUPPORTED = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ST_KNOWN   = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_ERROR   = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_ADD_OVF  = 4'd1;
  localparam logic [3:0] ERR_SUB_OVF  = 4'd2;
  localparam logic [3:0] ERR_MUL_OVF  = 4'd3;
  localparam logic [3:0] ERR_DIV_ZERO = 4'd4;
  localparam logic [3:0] ERR_DIV_OVF  = 4'd5;
  localparam logic [3:0] ERR_MOD_ZERO = 4'd6;
  localparam logic [3:0] ERR_MOD_OVF  = 4'd7;
  localparam logic [3:0] ERR_NEG_OVF  = 4'd8;

  // One beat as it travels down the cell chain.
  typedef struct packed {
    logic        chain_op;  // result comes from the cell chain
    logic        is_mul;
    logic        is_mod;
    logic        neg;       // sign of product or quotient
    logic        rem_neg;   // sign of the remainder
    logic [1:0]  status;
    logic [63:0] value;
    logic [3:0]  err;
    logic [63:0] acc;
    logic [63:0] sh;
    logic [63:0] opnd;
    logic        ovf;
  } lane_t;

endpackage

/* design/cai_if.sv */
// ------------------------------------------------------------------------
// cai_in_if / cai_out_if
// Valid/ready channels of the checked 64-bit integer ALU.
// ------------------------------------------------------------------------
interface cai_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [1:0]  lhs_status;
  logic signed [63:0] lhs_value;
  logic [3:0]  lhs_error;
  logic [1:0]  rhs_status;
  logic signed [63:0] rhs_value;
  logic [3:0]  rhs_error;

  modport source (output valid, kind, lhs_status, lhs_value, lhs_error,
                  rhs_status, rhs_value, rhs_error, input ready);
  modport sink (input valid, kind, lhs_status, lhs_value, lhs_error,
                rhs_status, rhs_value, rhs_error, output ready);
endinterface

interface cai_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_status;
  logic signed [63:0] result_value;
  logic [3:0]  error_code;

  modport source (output valid, result_status, result_value, error_code,
                  input ready);
  modport sink (input valid, result_status, result_value, error_code,
                output ready);
endinterface

/* design/cai_front.sv */
// ------------------------------------------------------------------------
// cai_front
// Decodes an operation and settles all results that need no cell chain.
// ------------------------------------------------------------------------
module cai_front import cai_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [3:0]  kind_i,
  input  logic [1:0]  lhs_status_i,
  input  logic [63:0] lhs_value_i,
  input  logic [3:0]  lhs_error_i,
  input  logic [1:0]  rhs_status_i,
  input  logic [63:0] rhs_value_i,
  input  logic [3:0]  rhs_error_i,
  output logic        valid_o,
  output lane_t       lane_o
);

  logic        valid_q;
  lane_t       lane_d, lane_q;
  logic [63:0] a, b, sum, dif, mag_a, mag_b;
  logic        a_neg, b_neg, a_zero, b_zero, lt, eq;

  assign a      = lhs_value_i;
  assign b      = rhs_value_i;
  assign a_neg  = a[63];
  assign b_neg  = b[63];
  assign a_zero = (a == '0);
  assign b_zero = (b == '0);
  assign sum    = a + b;
  assign dif    = a - b;
  assign mag_a  = a_neg ? (64'd0 - a) : a;
  assign mag_b  = b_neg ? (64'd0 - b) : b;
  assign lt     = ($signed(a) < $signed(b));
  assign eq     = (a == b);

  always_comb begin
    lane_d          = '0;
    lane_d.status   = ST_KNOWN;
    unique case (op_e'(kind_i))
      OP_NEG, OP_NOT: begin
        if (rhs_status_i == ST_ERROR) begin
          lane_d.status = ST_ERROR;
          lane_d.err    = rhs_error_i;
        end else if (rhs_status_i != ST_KNOWN) begin
          lane_d.status = ST_UNKNOWN;
        end else if (op_e'(kind_i) == OP_NOT) begin
          lane_d.value = {63'd0, b_zero};
        end else if (b == SignBit) begin
          lane_d.status = ST_ERROR;
          lane_d.err    = ERR_NEG_OVF;
        end else begin
          lane_d.value = 64'd0 - b;
        end
      end
      default: begin
        if (lhs_status_i == ST_ERROR) begin
          lane_d.status = ST_ERROR;
          lane_d.err    = lhs_error_i;
        end else if (rhs_status_i == ST_ERROR) begin
          lane_d.status = ST_ERROR;
          lane_d.err    = rhs_error_i;
        end else if (lhs_status_i != ST_KNOWN || rhs_status_i != ST_KNOWN) begin
          lane_d.status = ST_UNKNOWN;
        end else begin
          case (op_e'(kind_i))
            OP_ADD: begin
              if (a_neg == b_neg && sum[63] != a_neg) begin
                lane_d.status = ST_ERROR;
                lane_d.err    = ERR_ADD_OVF;
              end else begin
                lane_d.value = sum;
              end
            end
            OP_SUB: begin
              if (a_neg != b_neg && dif[63] != a_neg) begin
                lane_d.status = ST_ERROR;
                lane_d.err    = ERR_SUB_OVF;
              end else begin
                lane_d.value = dif;
              end
            end
            OP_MUL: begin
              if (!a_zero && !b_zero) begin
                lane_d.chain_op = 1'b1;
                lane_d.is_mul   = 1'b1;
                lane_d.neg      = a_neg ^ b_neg;
                lane_d.sh       = mag_b;
                lane_d.opnd     = mag_a;
              end
            end
            OP_DIV, OP_MOD: begin
              if (b_zero) begin
                lane_d.status = ST_ERROR;
                lane_d.err    = (op_e'(kind_i) == OP_DIV) ? ERR_DIV_ZERO : ERR_MOD_ZERO;
              end else if (a == SignBit && b == '1) begin
                lane_d.status = ST_ERROR;
                lane_d.err    = (op_e'(kind_i) == OP_DIV) ? ERR_DIV_OVF : ERR_MOD_OVF;
              end else begin
                lane_d.chain_op = 1'b1;
                lane_d.is_mod   = (op_e'(kind_i) == OP_MOD);
                lane_d.neg      = a_neg ^ b_neg;
                lane_d.rem_neg  = a_neg;
                lane_d.sh       = mag_a;
                lane_d.opnd     = mag_b;
              end
            end
            OP_EQ:  lane_d.value = {63'd0, eq};
            OP_NE:  lane_d.value = {63'd0, !eq};
            OP_LT:  lane_d.value = {63'd0, lt};
            OP_GT:  lane_d.value = {63'd0, !lt && !eq};
            OP_LE:  lane_d.value = {63'd0, lt || eq};
            OP_GE:  lane_d.value = {63'd0, !lt};
            OP_AND: lane_d.value = {63'd0, !a_zero && !b_zero};
            OP_OR:  lane_d.value = {63'd0, !a_zero || !b_zero};
            default: lane_d.status = ST_UNKNOWN;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

/* design/cai_cell.sv */
// ------------------------------------------------------------------------
// cai_cell
// One step of shift-add multiply or restoring divide, then a register.
// ------------------------------------------------------------------------
module cai_cell import cai_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  lane_t lane_i,
  output logic  valid_o,
  output lane_t lane_o
);

  logic        valid_q;
  lane_t       lane_d, lane_q;
  logic        top_bit, ge;
  logic [63:0] dbl, rem;
  logic [64:0] msum;

  assign top_bit = lane_i.sh[63];
  assign dbl     = {lane_i.acc[62:0], 1'b0};
  assign msum    = {1'b0, dbl} + (top_bit ? {1'b0, lane_i.opnd} : 65'd0);
  assign rem     = {lane_i.acc[62:0], top_bit};
  assign ge      = (rem >= lane_i.opnd);

  always_comb begin
    lane_d = lane_i;
    if (lane_i.chain_op) begin
      if (lane_i.is_mul) begin
        // Operand bits enter MSB first; any carry out of 64 bits is sticky.
        lane_d.acc = msum[63:0];
        lane_d.ovf = lane_i.ovf | lane_i.acc[63] | msum[64];
        lane_d.sh  = {lane_i.sh[62:0], 1'b0};
      end else begin
        lane_d.acc = ge ? (rem - lane_i.opnd) : rem;
        lane_d.sh  = {lane_i.sh[62:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

/* design/cai_back.sv */
// ------------------------------------------------------------------------
// cai_back
// Applies signs and the product range check, and holds the output beat.
// ------------------------------------------------------------------------
module cai_back import cai_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  lane_t       lane_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [63:0] value_o,
  output logic [3:0]  err_o
);

  logic        valid_q;
  logic [1:0]  status_d, status_q;
  logic [63:0] value_d, value_q, mag, limit;
  logic [3:0]  err_d, err_q;
  logic        sgn;

  assign limit = lane_i.neg ? SignBit : (SignBit - 64'd1);

  always_comb begin
    status_d = lane_i.status;
    value_d  = lane_i.value;
    err_d    = lane_i.err;
    mag      = lane_i.is_mod ? lane_i.acc : (lane_i.is_mul ? lane_i.acc : lane_i.sh);
    sgn      = lane_i.is_mod ? lane_i.rem_neg : lane_i.neg;
    if (lane_i.chain_op) begin
      if (lane_i.is_mul && (lane_i.ovf || lane_i.acc > limit)) begin
        status_d = ST_ERROR;
        value_d  = '0;
        err_d    = ERR_MUL_OVF;
      end else begin
        value_d  = sgn ? (64'd0 - mag) : mag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      status_q <= status_d;
      value_q  <= value_d;
      err_q    <= err_d;
    end
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign value_o  = value_q;
  assign err_o    = err_q;

endmodule

/* design/checked_int64_alu.sv */
// ------------------------------------------------------------------------
// checked_int64_alu
// Overflow-checked signed 64-bit ALU for one expression node per beat.
// ------------------------------------------------------------------------
// The in_i channel carries an opcode and two tagged operands; out_o
// returns one tagged result per input beat, in order.
// Every operation passes through one decode stage, a chain of
// 64 cells that each resolve one multiplier or quotient bit, and one
// output stage that applies signs and the product range check.
// Throughput is one beat per cycle while out_o is not stalled; the cell chain sets the latency.
// The whole pipeline advances when the output register is empty or being
// taken, so in_i.ready follows out_o.ready while a result is waiting.
// A stalled receiver holds the pipeline and the output beat unchanged.
// Reset clears all valid flags; no results are pending afterwards.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module checked_int64_alu import cai_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  cai_in_if.sink    in_i,
  cai_out_if.source out_o
);

  logic                 en;
  logic  [NumCells:0]   valid;
  lane_t [NumCells:0]   lane;

  assign en        = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  cai_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_i.valid),
    .kind_i       (in_i.kind),
    .lhs_status_i (in_i.lhs_status),
    .lhs_value_i  (in_i.lhs_value),
    .lhs_error_i  (in_i.lhs_error),
    .rhs_status_i (in_i.rhs_status),
    .rhs_value_i  (in_i.rhs_value),
    .rhs_error_i  (in_i.rhs_error),
    .valid_o      (valid[0]),
    .lane_o       (lane[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    cai_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid[i]),
      .lane_i  (lane[i]),
      .valid_o (valid[i+1]),
      .lane_o  (lane[i+1])
    );
  end

  cai_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (valid[NumCells]),
    .lane_i   (lane[NumCells]),
    .valid_o  (out_o.valid),
    .status_o (out_o.result_status),
    .value_o  (out_o.result_value),
    .err_o    (out_o.error_code)
  );

  `CAI_ASSERT_IMP(a_value_zero, out_o.valid && out_o.result_status != ST_KNOWN, out_o.result_value == '0)
  `CAI_ASSERT_IMP(a_err_zero, out_o.valid && out_o.result_status != ST_ERROR, out_o.error_code == ERR_NONE)
  `CAI_ASSERT_IMP(a_stall_hold, out_o.valid && !out_o.ready, !in_i.ready)

endmodule
